@@ sv/glos_pkg.sv @@
// ----------------------------------------------------------------------------
// glos_pkg
// Shared types and constants of the grid line-of-sight block.
// ----------------------------------------------------------------------------
package glos_pkg;

    // Fixed width of every coordinate field.
    localparam int COORD_W = 6;

    // Largest side that the coordinate fields can reach.
    localparam int COORD_SIDE = 1 << COORD_W;

    // Default side of the square occupancy map.
    localparam int DEFAULT_GRID_SIDE = 64;

    // Width of the signed Bresenham error term; its doubled value is one bit wider.
    localparam int ERR_W = COORD_W + 3;

    // Item function codes.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_HOLD
    } glos_state_t;

endpackage

@@ sv/grid_line_of_sight.sv @@
// ----------------------------------------------------------------------------
// grid_line_of_sight
// Occupancy grid with a Bresenham line-of-sight query.
// ----------------------------------------------------------------------------
// The block keeps a square occupancy bitmap in a single-port RAM with one
// bit per cell. After reset it runs a clearing pass that writes every cell
// to clear, one cell a cycle; no input beat is taken during the pass. A
// write beat (func low) sets or clears one cell; a write outside the grid
// is dropped. A query beat (func high) walks the integer Bresenham line
// from the start cell to the end cell, one cell a cycle, and reads each
// cell after the start from the RAM; the start cell itself is never
// checked, and cells outside the grid read as clear. The walk stops at the
// first blocked cell. Since the RAM has one port and a registered read, a
// query occupies the block while it steps, then while it checks the last
// read, and then until it hands the result to the output register, which
// waits while an earlier result is still held there. Items are taken one
// at a time, but the output register lets a new beat in while the
// previous result still waits to be taken. Writes give no result beat;
// each query gives exactly one.
// ----------------------------------------------------------------------------
module grid_line_of_sight #(
    parameter int GRID_SIDE = glos_pkg::DEFAULT_GRID_SIDE
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         func,
    input  logic [glos_pkg::COORD_W-1:0] start_x,
    input  logic [glos_pkg::COORD_W-1:0] start_y,
    input  logic [glos_pkg::COORD_W-1:0] end_x,
    input  logic [glos_pkg::COORD_W-1:0] end_y,
    input  logic                         cell_blocked,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         visible
);

    import glos_pkg::*;

    // Only cells that the coordinate fields can reach need storage.
    localparam int SIDE_EFF = (GRID_SIDE < COORD_SIDE) ? GRID_SIDE : COORD_SIDE;
    localparam int DEPTH    = SIDE_EFF * SIDE_EFF;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam logic [COORD_W:0]  SIDE_LIM = (COORD_W + 1)'(SIDE_EFF);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef logic [COORD_W-1:0] coord_t;

    // True when the cell lies inside the grid.
    function automatic logic in_grid(input coord_t x, input coord_t y);
        in_grid = ({1'b0, x} < SIDE_LIM) && ({1'b0, y} < SIDE_LIM);
    endfunction

    // Row-major RAM address of a cell; only meaningful inside the grid.
    function automatic logic [ADDR_W-1:0] cell_addr(input coord_t x, input coord_t y);
        cell_addr = ADDR_W'(ADDR_W'(y) * ADDR_W'(SIDE_EFF) + ADDR_W'(x));
    endfunction

    glos_state_t state_reg, state_next;

    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic              out_valid_reg, out_valid_next;
    logic              visible_reg, visible_next;

    // Walk registers.
    coord_t                   x_reg, x_next;
    coord_t                   y_reg, y_next;
    coord_t                   ex_reg, ex_next;
    coord_t                   ey_reg, ey_next;
    coord_t                   dx_reg, dx_next;
    coord_t                   dy_reg, dy_next;
    logic                     sx_reg, sx_next;
    logic                     sy_reg, sy_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic                     chk_reg, chk_next;
    logic                     vis_reg, vis_next;

    // RAM port.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic              ram_wdata;
    logic              ram_rdata;

    // Step arithmetic.
    logic signed [ERR_W:0]   e2;
    logic signed [ERR_W:0]   dx_s;
    logic signed [ERR_W:0]   dy_s;
    logic                    step_x;
    logic                    step_y;
    coord_t                  x_step;
    coord_t                  y_step;
    logic signed [ERR_W-1:0] err_step;
    logic                    at_end;
    logic                    hit;
    logic                    in_take;
    coord_t                  dx_in;
    coord_t                  dy_in;

    glos_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // One Bresenham step from the current cell. The error term doubles into
    // e2 and is compared against -dy and dx to decide which axes move.
    always_comb
    begin
        e2       = {err_reg, 1'b0};
        dx_s     = $signed((ERR_W + 1)'(dx_reg));
        dy_s     = $signed((ERR_W + 1)'(dy_reg));
        step_x   = (e2 > -dy_s);
        step_y   = (e2 < dx_s);
        x_step   = step_x ? (sx_reg ? x_reg + 1'b1 : x_reg - 1'b1) : x_reg;
        y_step   = step_y ? (sy_reg ? y_reg + 1'b1 : y_reg - 1'b1) : y_reg;
        err_step = ERR_W'(err_reg
                          - (step_x ? $signed(ERR_W'(dy_reg)) : ERR_W'(0))
                          + (step_y ? $signed(ERR_W'(dx_reg)) : ERR_W'(0)));
        at_end   = (x_reg == ex_reg) && (y_reg == ey_reg);
        // The cell read in the previous cycle is blocked.
        hit      = chk_reg && ram_rdata;
        in_take  = in_valid && !in_stall;
        dx_in    = (end_x > start_x) ? end_x - start_x : start_x - end_x;
        dy_in    = (end_y > start_y) ? end_y - start_y : start_y - end_y;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && out_stall;
        visible_next   = visible_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        ex_next        = ex_reg;
        ey_next        = ey_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        err_next       = err_reg;
        chk_next       = 1'b0;
        vis_next       = vis_reg;
        ram_we         = 1'b0;
        ram_addr       = clr_reg;
        ram_wdata      = 1'b0;
        in_stall       = 1'b1;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                in_stall = 1'b0;
                ram_addr = cell_addr(start_x, start_y);
                if (in_take)
                begin
                    if (func == FUNC_WRITE)
                    begin
                        ram_we    = in_grid(start_x, start_y);
                        ram_wdata = cell_blocked;
                    end
                    else
                    begin
                        x_next     = start_x;
                        y_next     = start_y;
                        ex_next    = end_x;
                        ey_next    = end_y;
                        dx_next    = dx_in;
                        dy_next    = dy_in;
                        sx_next    = (start_x < end_x);
                        sy_next    = (start_y < end_y);
                        err_next   = ERR_W'($signed(ERR_W'(dx_in)) - $signed(ERR_W'(dy_in)));
                        state_next = ST_WALK;
                    end
                end
            end

            ST_WALK:
            begin
                ram_addr = cell_addr(x_step, y_step);
                if (hit)
                begin
                    vis_next   = 1'b0;
                    state_next = ST_HOLD;
                end
                else if (at_end)
                begin
                    vis_next   = 1'b1;
                    state_next = ST_HOLD;
                end
                else
                begin
                    x_next   = x_step;
                    y_next   = y_step;
                    err_next = err_step;
                    chk_next = in_grid(x_step, y_step);
                end
            end

            ST_HOLD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    visible_next   = vis_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            chk_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            chk_reg       <= chk_next;
        end
    end

    // Payload and walk registers.
    always_ff @(posedge clk)
    begin
        visible_reg <= visible_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        ex_reg      <= ex_next;
        ey_reg      <= ey_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        err_reg     <= err_next;
        vis_reg     <= vis_next;
    end

    assign out_valid = out_valid_reg;
    assign visible   = visible_reg;

endmodule

@@ sv/glos_ram.sv @@
// ----------------------------------------------------------------------------
// glos_ram
// Generic single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module glos_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rd_data_reg <= mem_reg[addr];
    end

    assign rdata = rd_data_reg;

endmodule
